// File: rtl/core/wfba_pkg.sv
// ----------------------------------------------------------------------------
// wfba_pkg: shared types and constants for the worst-fit block allocator
// Table geometry, operation codes, scan word, cell write control, sequencer states and the saturation helper.
// ----------------------------------------------------------------------------
package wfba_pkg;

	localparam int BLOCKS    = 16;
	localparam int SIZE_BITS = 16;

	localparam int AMT_W   = 16;
	localparam int IDX_O_W = 4;
	localparam int SUM_W   = 20;
	localparam int IDX_W   = $clog2(BLOCKS);
	localparam int CNT_W   = $clog2(BLOCKS + 1);
	localparam int WIDE_W  = ((SIZE_BITS + IDX_W > SUM_W) ? SIZE_BITS + IDX_W : SUM_W) + 1;

	localparam logic [WIDE_W-1:0] SUM_MAX  = WIDE_W'((64'd1 << SUM_W) - 64'd1);
	localparam logic [WIDE_W-1:0] LEFT_MAX = WIDE_W'((64'd1 << AMT_W) - 64'd1);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// Word moving down the row of cells during a scan.
	typedef struct packed {
		logic                 vld;
		logic                 found;
		logic [SIZE_BITS-1:0] size;
		logic [IDX_W-1:0]     idx;
	} scan_tok_t;

	// Broadcast write control to every cell.
	typedef struct packed {
		logic                 load;
		logic                 mark;
		logic [IDX_W-1:0]     sel;
		logic [SIZE_BITS-1:0] wdata;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK
	} state_t;

	function automatic logic [SUM_W-1:0] sat_sum(input logic [WIDE_W-1:0] v);
		logic [SUM_W-1:0] r;
		r = (v > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : v[SUM_W-1:0];
		return r;
	endfunction

endpackage

// File: rtl/core/worst_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// worst_fit_block_allocator: fixed-partition worst-fit block allocator
// Loads block sizes into a row of cells and places requests in the largest
// free block, tracking internal fragmentation and total free size.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | dir | word
//  --------+----------------------------------+-----+---------------------------------
//  in      | in_valid / in_ready              | in  | op, amount
//  out     | out_valid / out_ready            | out | accepted, block_index, leftover,
//          |                                  |     | internal_total, free_total
//
// A load word finishes in the cycle it is taken; its result is registered
// at that edge, so loads can follow back to back. An allocate word walks the
// scan word through the row of BLOCKS cells, one cell per cycle; the last
// cell's word is registered as the winner, then ST_PICK registers the result
// and updates the table, and the next word can be taken once the sequencer
// is back in ST_IDLE. One word is in flight at a time; a new word is taken
// once the output register is empty or is being drained in that same cycle.
// Reset clears all flags, the load count and the running sums at once.
module worst_fit_block_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [wfba_pkg::AMT_W-1:0]     amount,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           accepted,
	output logic [wfba_pkg::IDX_O_W-1:0]   block_index,
	output logic [wfba_pkg::AMT_W-1:0]     leftover,
	output logic [wfba_pkg::SUM_W-1:0]     internal_total,
	output logic [wfba_pkg::SUM_W-1:0]     free_total
);
	import wfba_pkg::*;

	state_t state_q, state_d;

	logic                 out_valid_q;
	logic                 accepted_q;
	logic [IDX_O_W-1:0]   block_index_q;
	logic [AMT_W-1:0]     leftover_q;
	logic [SUM_W-1:0]     free_total_q;

	logic [CNT_W-1:0]     loaded_cnt_q;
	logic [SUM_W-1:0]     internal_q;
	logic [WIDE_W-1:0]    free_true_q;   // exact free sum, saturated only on output
	logic [AMT_W-1:0]     amount_q;
	scan_tok_t            best_q;

	scan_tok_t            tok_w [BLOCKS+1];
	cell_ctl_t            ctl;

	logic                 take_in;
	logic                 out_free;
	logic                 load_ok;
	logic [SIZE_BITS-1:0] load_size;
	logic                 fits;
	logic [SIZE_BITS-1:0] left;
	logic [WIDE_W-1:0]    left_w;
	logic [WIDE_W-1:0]    int_new;
	logic [WIDE_W-1:0]    free_after_load;
	logic [WIDE_W-1:0]    free_after_pick;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign take_in  = in_valid && in_ready;

	// load path
	assign load_ok         = (loaded_cnt_q < CNT_W'(BLOCKS));
	assign load_size       = SIZE_BITS'(amount);
	assign free_after_load = free_true_q + WIDE_W'(load_size);

	// pick path, from the registered winner of the scan
	assign fits            = best_q.found && (WIDE_W'(best_q.size) >= WIDE_W'(amount_q));
	assign left            = best_q.size - SIZE_BITS'(amount_q);
	assign left_w          = WIDE_W'(left);
	assign int_new         = WIDE_W'(internal_q) + left_w;
	assign free_after_pick = free_true_q - WIDE_W'(best_q.size);

	// scan word enters cell 0 when an allocate word is taken
	always_comb begin
		tok_w[0].vld   = take_in && (op == OP_ALLOC);
		tok_w[0].found = 1'b0;
		tok_w[0].size  = '0;
		tok_w[0].idx   = '0;
	end

	always_comb begin
		ctl.load  = take_in && (op == OP_LOAD) && load_ok;
		ctl.mark  = (state_q == ST_PICK) && fits;
		ctl.sel   = (state_q == ST_PICK) ? best_q.idx : IDX_W'(loaded_cnt_q);
		ctl.wdata = load_size;
	end

	for (genvar k = 0; k < BLOCKS; k++) begin : g_cell
		wfba_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_idx(IDX_W'(k)),
			.ctl     (ctl),
			.tok_in  (tok_w[k]),
			.tok_out (tok_w[k+1])
		);
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take_in && op == OP_ALLOC) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (tok_w[BLOCKS].vld) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state: counters, sums and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			loaded_cnt_q <= '0;
			internal_q   <= '0;
			free_true_q  <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take_in && op == OP_LOAD) begin
				out_valid_q <= 1'b1;
				if (load_ok) begin
					loaded_cnt_q <= loaded_cnt_q + CNT_W'(1);
					free_true_q  <= free_after_load;
				end
			end
			if (state_q == ST_PICK) begin
				out_valid_q <= 1'b1;
				if (fits) begin
					internal_q  <= sat_sum(int_new);
					free_true_q <= free_after_pick;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			amount_q <= amount;
		end
		if (state_q == ST_SCAN && tok_w[BLOCKS].vld) begin
			best_q <= tok_w[BLOCKS];
		end
		if (take_in && op == OP_LOAD) begin
			accepted_q    <= load_ok;
			block_index_q <= load_ok ? IDX_O_W'(loaded_cnt_q) : '0;
			leftover_q    <= '0;
			free_total_q  <= sat_sum(load_ok ? free_after_load : free_true_q);
		end
		if (state_q == ST_PICK) begin
			accepted_q    <= fits;
			block_index_q <= fits ? IDX_O_W'(best_q.idx) : '0;
			leftover_q    <= !fits ? '0 :
			                 (left_w > LEFT_MAX) ? LEFT_MAX[AMT_W-1:0] : left_w[AMT_W-1:0];
			free_total_q  <= sat_sum(fits ? free_after_pick : free_true_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = accepted_q;
	assign block_index    = block_index_q;
	assign leftover       = leftover_q;
	assign internal_total = internal_q;
	assign free_total     = free_total_q;

endmodule

// File: rtl/core/wfba_cell.sv
// ----------------------------------------------------------------------------
// wfba_cell: one table entry of the allocator
// Holds a block size and its flags; keeps the running best of the scan word.
// ----------------------------------------------------------------------------
module wfba_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [wfba_pkg::IDX_W-1:0] cell_idx,
	input  wfba_pkg::cell_ctl_t ctl,
	input  wfba_pkg::scan_tok_t tok_in,
	output wfba_pkg::scan_tok_t tok_out
);
	import wfba_pkg::*;

	logic                 loaded_q;
	logic                 used_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 hit;
	logic                 take;
	scan_tok_t            tok_q;

	assign hit  = (ctl.sel == cell_idx);
	// strict greater keeps the lowest index on a tie
	assign take = loaded_q && !used_q && (!tok_in.found || size_q > tok_in.size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			used_q   <= 1'b0;
		end else if (ctl.load && hit) begin
			loaded_q <= 1'b1;
			used_q   <= 1'b0;
		end else if (ctl.mark && hit) begin
			used_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && hit) begin
			size_q <= ctl.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.vld <= tok_in.vld;
			if (tok_in.vld && take) begin
				tok_q.found <= 1'b1;
				tok_q.size  <= size_q;
				tok_q.idx   <= cell_idx;
			end else begin
				tok_q.found <= tok_in.found;
				tok_q.size  <= tok_in.size;
				tok_q.idx   <= tok_in.idx;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// File: test/worst_fit_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// worst_fit_block_allocator_tb: self-checking bench for the worst-fit allocator
// A directed table covers the corner cases, then random load/allocate traffic
// runs under four flow-control phases. A behavioral copy of the block table
// predicts the result words of untyped rows; each word is checked field by field in order.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator_tb;

	import wfba_pkg::*;

	// One result word, in port order.
	typedef struct packed {
		logic               accepted;
		logic [IDX_O_W-1:0] block_index;
		logic [AMT_W-1:0]   leftover;
		logic [SUM_W-1:0]   internal_total;
		logic [SUM_W-1:0]   free_total;
	} alloc_res_t;

	// Directed stimulus row; typed rows carry their own expected word.
	typedef struct packed {
		logic             op;
		logic [AMT_W-1:0] amount;
		logic             typed;
		alloc_res_t       want;
	} alloc_row_t;

	localparam int NUM_DIR        = 16;
	localparam int RAND_PER_PHASE = 440;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int DRAIN_CYCLES   = 2 * (BLOCKS + 2) + 4;
	localparam int MAX_REPORTS    = 10;
	localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 64'd1;
	localparam longint unsigned LEFT_CAP = (64'd1 << AMT_W) - 64'd1;

	// Sender idle / receiver stall percentages per random phase.
	localparam int PHASE_IDLE [4]  = '{0, 71, 0, 38};
	localparam int PHASE_STALL [4] = '{0, 0, 71, 38};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 op = OP_LOAD;
	logic [AMT_W-1:0]     amount = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 accepted;
	logic [IDX_O_W-1:0]   block_index;
	logic [AMT_W-1:0]     leftover;
	logic [SUM_W-1:0]     internal_total;
	logic [SUM_W-1:0]     free_total;

	worst_fit_block_allocator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.amount         (amount),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.block_index    (block_index),
		.leftover       (leftover),
		.internal_total (internal_total),
		.free_total     (free_total)
	);

	// Shadow of the block table and running sums.
	logic [SIZE_BITS-1:0] tbl_size [BLOCKS];
	bit                   tbl_used [BLOCKS];
	int unsigned          n_loaded = 0;
	longint unsigned      frag_sum = 0;

	alloc_res_t  pending_results [$];
	alloc_row_t  directed_rows [NUM_DIR];
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          errors = 0;
	int          cycle_cnt = 0;
	int          words_sent = 0;
	int          loads_ok = 0;
	int          allocs_ok = 0;
	int          refusals = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned sat_add(longint unsigned x, longint unsigned y);
		return (x + y > SUM_CAP) ? SUM_CAP : x + y;
	endfunction

	// Largest free loaded block, lowest index on a tie; -1 if none is free.
	function automatic int largest_free();
		int best;
		best = -1;
		for (int k = 0; k < n_loaded; k++) begin
			if (!tbl_used[k] && (best < 0 || tbl_size[k] > tbl_size[best]))
				best = k;
		end
		return best;
	endfunction

	// Applies one input word to the shadow table and returns its result word.
	function automatic alloc_res_t place_word(logic o, logic [AMT_W-1:0] a);
		alloc_res_t      r;
		int              best;
		longint unsigned left;
		longint unsigned free_acc;
		r = '0;
		if (o == OP_LOAD) begin
			// table full: refused, nothing changes
			if (n_loaded < BLOCKS) begin
				tbl_size[n_loaded] = a[SIZE_BITS-1:0];
				tbl_used[n_loaded] = 1'b0;
				r.accepted = 1'b1;
				r.block_index = n_loaded[IDX_O_W-1:0];
				n_loaded++;
			end
		end else begin
			best = largest_free();
			// no free block or request too large: refused, block stays free
			if (best >= 0 && tbl_size[best] >= a) begin
				left = tbl_size[best] - a;
				tbl_used[best] = 1'b1;
				frag_sum = sat_add(frag_sum, left);
				r.accepted = 1'b1;
				r.block_index = best[IDX_O_W-1:0];
				r.leftover = (left > LEFT_CAP) ? LEFT_CAP[AMT_W-1:0] : left[AMT_W-1:0];
			end
		end
		free_acc = 0;
		for (int k = 0; k < n_loaded; k++) begin
			if (!tbl_used[k])
				free_acc = sat_add(free_acc, tbl_size[k]);
		end
		r.internal_total = frag_sum[SUM_W-1:0];
		r.free_total = free_acc[SUM_W-1:0];
		return r;
	endfunction

	// Presents one word, holds it until taken, then records the expected result.
	task automatic send_word(input logic o, input logic [AMT_W-1:0] a, input logic typed,
			input alloc_res_t want);
		alloc_res_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		amount <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = place_word(o, a);
		pending_results.push_back(typed ? want : predicted);
		words_sent++;
		if (!predicted.accepted)
			refusals++;
		else if (o == OP_LOAD)
			loads_ok++;
		else
			allocs_ok++;
	endtask

	// Result checker and receiver back-pressure.
	always @(posedge clk) begin
		alloc_res_t got;
		alloc_res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{accepted, block_index, leftover, internal_total, free_total};
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("ERROR: stray word acc=%0d idx=%0d left=%0d int=%0d free=%0d",
						got.accepted, got.block_index, got.leftover,
						got.internal_total, got.free_total);
			end else begin
				want = pending_results.pop_front();
				if (got.accepted !== want.accepted || got.block_index !== want.block_index ||
						got.leftover !== want.leftover ||
						got.internal_total !== want.internal_total ||
						got.free_total !== want.free_total) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("ERROR: exp acc=%0d idx=%0d left=%0d int=%0d free=%0d",
							want.accepted, want.block_index, want.leftover,
							want.internal_total, want.free_total);
						$display("       got acc=%0d idx=%0d left=%0d int=%0d free=%0d",
							got.accepted, got.block_index, got.leftover,
							got.internal_total, got.free_total);
					end
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results pending", cycle_cnt,
				pending_results.size());
			$display("worst_fit_block_allocator_tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic             o;
		logic [AMT_W-1:0] a;
		int               best;

		// Directed corners: empty table, size extremes, zero request, reuse of
		// a used block, one-over request, tie on size, alternating bit patterns.
		directed_rows = '{
			'{OP_ALLOC, 16'h0000, 1'b1, '{1'b0, 4'd0, 16'd0,     20'd0,     20'd0}},
			'{OP_LOAD,  16'hFFFF, 1'b1, '{1'b1, 4'd0, 16'd0,     20'd0,     20'd65535}},
			'{OP_LOAD,  16'h0000, 1'b1, '{1'b1, 4'd1, 16'd0,     20'd0,     20'd65535}},
			'{OP_ALLOC, 16'hFFFF, 1'b1, '{1'b1, 4'd0, 16'd0,     20'd0,     20'd0}},
			'{OP_ALLOC, 16'h0000, 1'b1, '{1'b1, 4'd1, 16'd0,     20'd0,     20'd0}},
			'{OP_ALLOC, 16'h0000, 1'b1, '{1'b0, 4'd0, 16'd0,     20'd0,     20'd0}},
			'{OP_LOAD,  16'd100,  1'b1, '{1'b1, 4'd2, 16'd0,     20'd0,     20'd100}},
			'{OP_LOAD,  16'd100,  1'b1, '{1'b1, 4'd3, 16'd0,     20'd0,     20'd200}},
			'{OP_ALLOC, 16'd101,  1'b1, '{1'b0, 4'd0, 16'd0,     20'd0,     20'd200}},
			'{OP_ALLOC, 16'd30,   1'b1, '{1'b1, 4'd2, 16'd70,    20'd70,    20'd100}},
			'{OP_ALLOC, 16'd0,    1'b1, '{1'b1, 4'd3, 16'd100,   20'd170,   20'd0}},
			'{OP_LOAD,  16'hAAAA, 1'b0, '0},
			'{OP_LOAD,  16'h5555, 1'b0, '0},
			'{OP_ALLOC, 16'h5555, 1'b0, '0},
			'{OP_ALLOC, 16'h0000, 1'b0, '0},
			'{OP_ALLOC, 16'hFFFF, 1'b0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < NUM_DIR; r++)
			send_word(directed_rows[r].op, directed_rows[r].amount, directed_rows[r].typed,
				directed_rows[r].want);

		// Random traffic: mostly oversized requests so placements are spread
		// over the whole run; loads keep coming after the table is full.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = PHASE_IDLE[ph];
			stall_pct = PHASE_STALL[ph];
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				best = largest_free();
				if ($urandom_range(7) == 0) begin
					o = OP_LOAD;
					a = AMT_W'($urandom);
				end else begin
					o = OP_ALLOC;
					if (best >= 0 && $urandom_range(249) == 0)
						a = AMT_W'($urandom_range(32'(tbl_size[best]), 0));
					else if (best >= 0 && tbl_size[best] != {SIZE_BITS{1'b1}} &&
							$urandom_range(99) != 0)
						a = AMT_W'($urandom_range(32'hFFFF, 32'(tbl_size[best]) + 1));
					else
						a = AMT_W'($urandom);
				end
				send_word(o, a, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words: %0d loads stored, %0d requests placed, %0d refused",
			words_sent, loads_ok, allocs_ok, refusals);
		$display("Four flow-control phases, %0d mismatches, %0d cycles", errors, cycle_cnt);
		if (errors == 0)
			$display("worst_fit_block_allocator_tb OK");
		else
			$display("worst_fit_block_allocator_tb NOT OK");
		$finish;
	end

endmodule
